### rtl/core/fpsa_pkg.sv
// Shared definitions for the free page stack allocator.
// Holds command and status codes, default sizes and the controller/datapath bundles.
// No dependencies.
package fpsa_pkg;

   localparam int ADDR_BITS = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam int DEF_MAX_PAGES = 32768;
   localparam int DEF_PAGE_BYTES = 4096;

   localparam logic [ADDR_BITS-1:0] START_RESET = 40'h00_8000_0000;
   localparam logic [ADDR_BITS-1:0] STOP_RESET = 40'h00_8800_0000;

   // Register indexes, selected by paddr bit 3.
   localparam logic CSR_REGION_START = 1'b0;
   localparam logic CSR_REGION_STOP = 1'b1;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE = 2'd1;
   localparam logic [1:0] CMD_INIT = 2'd2;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_BAD = 2'd2;
   localparam logic [1:0] STS_FULL = 2'd3;

   typedef struct packed {
      logic latch;
      logic exec;
      logic init_calc;
      logic fill_step;
      logic load_rsp;
   } fpsa_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       fill_done;
   } fpsa_status_type;

endpackage

### rtl/core/fpsa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds until the next read. No dependencies.
module fpsa_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 32768,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/fpsa_ctrl.sv
// Sequencing state machine for the free page stack allocator.
// Depends on fpsa_pkg; drives the datapath through fpsa_cmd_type.
module fpsa_ctrl
   import fpsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fpsa_cmd_type    cmd,
   input  fpsa_status_type sts
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_CALC = 5'b00100,
      S_FILL = 5'b01000,
      S_RESP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.latch = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = (sts.cmd == CMD_INIT) ? S_CALC : S_RESP;
         end
         S_CALC: begin
            cmd.init_calc = 1'b1;
            state_in = S_FILL;
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new result must never overwrite one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a pending beat");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted beat not executed next cycle");

endmodule

### rtl/core/fpsa_dp.sv
// Datapath of the free page stack allocator: region registers, stack count,
// free checks, init region arithmetic, stack RAM and result register.
// Depends on fpsa_pkg and fpsa_ram.
module fpsa_dp
   import fpsa_pkg::*;
#(
   parameter int MAX_PAGES = DEF_MAX_PAGES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_cmd,
   input  logic [ADDR_BITS-1:0]  req_addr,
   output logic [ADDR_BITS-1:0]  rsp_page_addr,
   output logic [1:0]            rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   input  fpsa_cmd_type          cmd,
   output fpsa_status_type       sts
);

   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PN_W = ADDR_BITS - PAGE_SHIFT;
   localparam int NRAW_W = ADDR_BITS + 1 - PAGE_SHIFT;
   localparam int CNT_W = $clog2(MAX_PAGES + 1);
   localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);
   localparam logic [NRAW_W-1:0] MAX_N = NRAW_W'(MAX_PAGES);
   localparam logic [ADDR_BITS:0] PAGE_MINUS1 = (ADDR_BITS + 1)'(PAGE_BYTES - 1);

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS-1:0] stop_ff, stop_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [NRAW_W-1:0]    first_ff, first_in;
   logic [CNT_W-1:0]     nlim_ff, nlim_in;
   logic [1:0]           status_ff, status_in;
   logic                 page_sel_ff, page_sel_in;
   logic [ADDR_BITS-1:0] rsp_page_ff, rsp_page_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   logic                 csr_wr;
   logic                 aligned, in_range, has_room;
   logic [CNT_W-1:0]     cnt_dec;
   logic [ADDR_BITS:0]   round_sum;
   logic [ADDR_BITS:0]   base;
   logic [ADDR_BITS:0]   diff;
   logic [NRAW_W-1:0]    n_raw;
   logic [NRAW_W-1:0]    fill_pn;
   logic                 fill_done;

   logic                 ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
   logic [PN_W-1:0]      ram_wr_data, ram_rd_data;

   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == CSR_REGION_STOP)
                       ? {{(CSR_DATA_W - ADDR_BITS){1'b0}}, stop_ff}
                       : {{(CSR_DATA_W - ADDR_BITS){1'b0}}, start_ff};

   assign aligned = (addr_ff[PAGE_SHIFT-1:0] == '0);
   assign in_range = (addr_ff >= start_ff) && (addr_ff < stop_ff);
   assign has_room = (count_ff != MAX_CNT);
   assign cnt_dec = count_ff - 1'b1;

   // Rounded-up first page; the sum is one bit wider so a start near the top
   // of the address space does not wrap.
   assign round_sum = {1'b0, start_ff} + PAGE_MINUS1;
   assign base = {first_ff, {PAGE_SHIFT{1'b0}}};
   assign diff = {1'b0, stop_ff} - base;
   // A borrow means the stop lies below the base, so the region is empty.
   assign n_raw = diff[ADDR_BITS] ? '0 : diff[ADDR_BITS:PAGE_SHIFT];

   assign fill_pn = first_ff + NRAW_W'(count_ff);
   assign fill_done = (count_ff == nlim_ff);

   always_comb begin
      start_in = start_ff;
      stop_in = stop_ff;
      if (csr_wr) begin
         if (csr_paddr[3] == CSR_REGION_STOP) begin
            stop_in = csr_pwdata[ADDR_BITS-1:0];
         end else begin
            start_in = csr_pwdata[ADDR_BITS-1:0];
         end
      end
   end

   always_comb begin
      cmd_in = cmd.latch ? req_cmd : cmd_ff;
      addr_in = cmd.latch ? req_addr : addr_ff;
      count_in = count_ff;
      first_in = first_ff;
      nlim_in = nlim_ff;
      status_in = status_ff;
      page_sel_in = page_sel_ff;
      ram_wr_en = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = fill_pn[PN_W-1:0];
      ram_rd_en = 1'b0;
      ram_rd_addr = cnt_dec[IDX_W-1:0];

      if (cmd.exec) begin
         page_sel_in = 1'b0;
         status_in = STS_OK;
         case (cmd_ff)
            CMD_ALLOC: begin
               if (count_ff == '0) begin
                  status_in = STS_EMPTY;
               end else begin
                  ram_rd_en = 1'b1;
                  count_in = cnt_dec;
                  page_sel_in = 1'b1;
               end
            end
            CMD_FREE: begin
               if (!(aligned && in_range)) begin
                  status_in = STS_BAD;
               end else if (!has_room) begin
                  status_in = STS_FULL;
               end else begin
                  ram_wr_en = 1'b1;
                  ram_wr_data = addr_ff[ADDR_BITS-1:PAGE_SHIFT];
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_INIT: begin
               first_in = round_sum[ADDR_BITS:PAGE_SHIFT];
               count_in = '0;
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
      end

      if (cmd.init_calc) begin
         if (n_raw > MAX_N) begin
            nlim_in = MAX_CNT;
            status_in = STS_FULL;
         end else begin
            nlim_in = n_raw[CNT_W-1:0];
            status_in = STS_OK;
         end
      end

      if (cmd.fill_step && !fill_done) begin
         ram_wr_en = 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   assign rsp_page_in = page_sel_ff ? {ram_rd_data, {PAGE_SHIFT{1'b0}}} : '0;
   assign rsp_status_in = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         stop_ff <= STOP_RESET;
         count_ff <= '0;
      end else begin
         start_ff <= start_in;
         stop_ff <= stop_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      addr_ff <= addr_in;
      first_ff <= first_in;
      nlim_ff <= nlim_in;
      status_ff <= status_in;
      page_sel_ff <= page_sel_in;
      if (cmd.load_rsp) begin
         rsp_page_ff <= rsp_page_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   fpsa_ram #(
      .WIDTH(PN_W),
      .DEPTH(MAX_PAGES),
      .AW   (IDX_W)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_page_addr = rsp_page_ff;
   assign rsp_status = rsp_status_ff;
   assign sts.cmd = cmd_ff;
   assign sts.fill_done = fill_done;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("stack count beyond capacity");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (count_ff != MAX_CNT))
      else $error("push onto a full stack");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && cmd_ff == CMD_ALLOC && count_ff != '0)
      |=> (count_ff == $past(cnt_dec)))
      else $error("pop did not decrement the stack count");

endmodule

### rtl/core/free_page_stack_allocator_core.sv
// Free page stack allocator: a LIFO stack of free physical page numbers.
//
// Request channel (req_valid/req_stall, req_cmd, req_addr) takes one command
// per beat: allocate, free, or initialize from the configured region. Every
// request gives exactly one beat on the response channel (rsp_valid/rsp_stall,
// rsp_page_addr, rsp_status). The user must write region start and stop over
// the APB-style csr_ port while no request is in flight; nothing enforces it.
//
// Allocate, free and the unused command run through the execute and response
// states; req_stall holds off a new request until the response is loaded,
// and one can be accepted in the cycle that beat is first offered. Each
// command runs through the one stack RAM port pair, with the registered read
// setting the allocate latency. Initialize runs through execute, region
// calculation, fill with one RAM write per cycle per pushed page, and response.
//
// A result waits in the output register while rsp_stall is high; the block
// still accepts and runs the next request, then holds that result and keeps
// req_stall high until the waiting beat leaves. Reset empties the stack
// (count to zero, no clearing pass over the RAM) and restores the reset
// region; stack entries are read only below the count, so the RAM contents
// need no reset.
// Depends on fpsa_pkg, fpsa_ctrl, fpsa_dp and fpsa_ram.
module free_page_stack_allocator_core
   import fpsa_pkg::*;
#(
   parameter int MAX_PAGES = DEF_MAX_PAGES,
   parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [ADDR_BITS-1:0]  req_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_BITS-1:0]  rsp_page_addr,
   output logic [1:0]            rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   fpsa_cmd_type    cmd;
   fpsa_status_type sts;

   assign csr_pready = 1'b1;

   fpsa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   fpsa_dp #(
      .MAX_PAGES (MAX_PAGES),
      .PAGE_BYTES(PAGE_BYTES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_cmd),
      .req_addr     (req_addr),
      .rsp_page_addr(rsp_page_addr),
      .rsp_status   (rsp_status),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule

### tb/tb_free_page_stack_allocator_core.sv
// Self-checking testbench for free_page_stack_allocator_core.
// Holds its own model of the free page stack and checks every response beat against it.
// Depends on fpsa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_free_page_stack_allocator_core;
   import fpsa_pkg::*;

   localparam int STACK_DEPTH = DEF_MAX_PAGES;
   localparam logic [63:0] PAGE_SZ = 64'(DEF_PAGE_BYTES);
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_PER_PHASE = 275;
   localparam int HOLD_AT = 100;
   localparam int HOLD_CYCLES = 300;
   localparam longint TIMEOUT_CYCLES = 600000;
   localparam logic [ADDR_BITS-1:0] ADDR_TOP = {ADDR_BITS{1'b1}};

   typedef struct packed {
      logic [1:0]           cmd;
      logic [ADDR_BITS-1:0] addr;
      logic                 drain;
   } page_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] page_addr;
      logic [1:0]           status;
   } page_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_cmd = CMD_ALLOC;
   logic [ADDR_BITS-1:0]  req_addr = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ADDR_BITS-1:0]  rsp_page_addr;
   logic [1:0]            rsp_status;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Model state: the stack of free page numbers and the region registers.
   logic [ADDR_BITS-1:0] free_pg [0:STACK_DEPTH-1];
   int                   free_depth = 0;
   logic [ADDR_BITS-1:0] cfg_first_byte = START_RESET;
   logic [ADDR_BITS-1:0] cfg_end_byte = STOP_RESET;

   page_req_type pending_reqs[$];
   page_rsp_type awaited_rsps[$];

   int items_queued = 0;
   int beats_in = 0;
   int beats_out = 0;
   int mismatches = 0;
   int cfg_writes = 0;
   int sts_seen [0:3] = '{0, 0, 0, 0};
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   free_page_stack_allocator_core #(
      .MAX_PAGES(STACK_DEPTH),
      .PAGE_BYTES(DEF_PAGE_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_addr(req_addr),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_page_addr(rsp_page_addr),
      .rsp_status(rsp_status),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 12);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   // Applies one command to the model stack and returns the response it should produce.
   task automatic stack_apply(input logic [1:0] op, input logic [ADDR_BITS-1:0] a,
                              output logic [ADDR_BITS-1:0] pa, output logic [1:0] st);
      logic [63:0] a64, first, base, stop64, n, tmp;
      int k;
      pa = '0;
      st = STS_OK;
      a64 = a;
      case (op)
         CMD_ALLOC: begin
            if (free_depth == 0) begin
               st = STS_EMPTY;
            end else begin
               free_depth--;
               tmp = free_pg[free_depth];
               tmp = tmp * PAGE_SZ;
               pa = tmp[ADDR_BITS-1:0];
            end
         end
         CMD_FREE: begin
            if ((a64 % PAGE_SZ) != 0 || a < cfg_first_byte || a >= cfg_end_byte) begin
               st = STS_BAD;
            end else if (free_depth >= STACK_DEPTH) begin
               st = STS_FULL;
            end else begin
               tmp = a64 / PAGE_SZ;
               free_pg[free_depth] = tmp[ADDR_BITS-1:0];
               free_depth++;
            end
         end
         CMD_INIT: begin
            tmp = cfg_first_byte;
            first = (tmp + PAGE_SZ - 1) / PAGE_SZ;
            base = first * PAGE_SZ;
            stop64 = cfg_end_byte;
            n = 0;
            if (base <= stop64 && stop64 - base >= PAGE_SZ) n = (stop64 - base) / PAGE_SZ;
            if (n > STACK_DEPTH) begin
               n = STACK_DEPTH;
               st = STS_FULL;
            end
            for (k = 0; k < n; k++) begin
               tmp = first + k;
               free_pg[k] = tmp[ADDR_BITS-1:0];
            end
            free_depth = int'(n);
         end
         default: ;
      endcase
   endtask

   // Request driver: predicts on every accepted beat, then offers the next pending item.
   always @(posedge clock) begin : drive_req
      logic [ADDR_BITS-1:0] pa;
      logic [1:0]           st;
      page_rsp_type         want;
      page_req_type         nxt;
      bit                   took;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            stack_apply(req_cmd, req_addr, pa, st);
            want.page_addr = pa;
            want.status = st;
            awaited_rsps.push_back(want);
            beats_in++;
         end
         if (!req_valid || took) begin
            // An item marked drain waits until every outstanding response is back.
            if (pending_reqs.size() > 0 && !(pending_reqs[0].drain && awaited_rsps.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_cmd <= nxt.cmd;
               req_addr <= nxt.addr;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall: random per cycle, plus one long hold so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (!hold_done && beats_in >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (hold_left != 0) hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : watch_rsp
      page_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         sts_seen[rsp_status]++;
         if (awaited_rsps.size() == 0) begin
            flag_mismatch($sformatf("response beat with nothing outstanding (addr %h status %0d)",
                                    rsp_page_addr, rsp_status));
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_page_addr !== want.page_addr)
               flag_mismatch($sformatf("page_addr %h, expected %h", rsp_page_addr,
                                       want.page_addr));
            if (rsp_status !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
         end
      end
   end

   task automatic queue_item(input logic [1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                             input bit drain = 1'b0);
      page_req_type it;
      it.cmd = cmd;
      it.addr = addr;
      it.drain = drain;
      pending_reqs.push_back(it);
      items_queued++;
   endtask

   task automatic settle();
      while (beats_in != items_queued || awaited_rsps.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_rw(input bit wr, input logic idx, input logic [CSR_DATA_W-1:0] wdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      if (!wr && csr_prdata[ADDR_BITS-1:0] !==
          (idx == CSR_REGION_STOP ? cfg_end_byte : cfg_first_byte))
         flag_mismatch($sformatf("register %0d reads %h", idx, csr_prdata));
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (wr) begin
         if (idx == CSR_REGION_STOP) cfg_end_byte = wdata[ADDR_BITS-1:0];
         else cfg_first_byte = wdata[ADDR_BITS-1:0];
      end
   endtask

   task automatic set_region(input logic [63:0] first_byte, input logic [63:0] end_byte);
      logic [CSR_DATA_W-1:0] w;
      settle();
      // Bits above the address width are random; the block must ignore them.
      w = {$urandom, $urandom};
      w[ADDR_BITS-1:0] = first_byte[ADDR_BITS-1:0];
      csr_rw(1'b1, CSR_REGION_START, w);
      w = {$urandom, $urandom};
      w[ADDR_BITS-1:0] = end_byte[ADDR_BITS-1:0];
      csr_rw(1'b1, CSR_REGION_STOP, w);
      csr_rw(1'b0, CSR_REGION_START, '0);
      csr_rw(1'b0, CSR_REGION_STOP, '0);
      cfg_writes += 2;
   endtask

   // Builds one random command, mostly well-formed against the current region.
   function automatic page_req_type pick_item();
      page_req_type it;
      logic [63:0]  lo, hi, pg, v, r64;
      int           r;
      r = $urandom_range(99);
      r64 = {$urandom, $urandom};
      it.addr = r64[ADDR_BITS-1:0];
      it.drain = ($urandom_range(49) == 0);
      it.cmd = CMD_FREE;
      v = cfg_first_byte;
      lo = (v + PAGE_SZ - 1) / PAGE_SZ;
      v = cfg_end_byte;
      hi = (v + PAGE_SZ - 1) / PAGE_SZ;
      pg = (hi > lo) ? lo + ({$urandom, $urandom} % (hi - lo)) : lo;
      if (r < 38) begin
         it.cmd = CMD_ALLOC;
      end else if (r < 76) begin
         v = pg * PAGE_SZ;
         if (hi > lo) it.addr = v[ADDR_BITS-1:0];
      end else if (r < 82) begin
         v = pg * PAGE_SZ + $urandom_range(1, DEF_PAGE_BYTES - 1);
         it.addr = v[ADDR_BITS-1:0];
      end else if (r < 86) begin
         v = lo * PAGE_SZ - $urandom_range(1, 8) * PAGE_SZ;
         it.addr = v[ADDR_BITS-1:0];
      end else if (r < 89) begin
         v = hi * PAGE_SZ + $urandom_range(0, 3) * PAGE_SZ;
         it.addr = v[ADDR_BITS-1:0];
      end else if (r < 91) begin
         it.cmd = CMD_FREE;
      end else if (r < 96) begin
         it.cmd = CMD_INIT;
      end else begin
         it.cmd = CMD_UNUSED;
      end
      return it;
   endfunction

   initial begin : stimulus
      page_req_type it;
      logic [63:0]  base, r64;
      int           ph, k;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      csr_rw(1'b0, CSR_REGION_START, '0);
      csr_rw(1'b0, CSR_REGION_STOP, '0);

      // Directed: empty stack, bad frees of every kind, unused command, full stack.
      queue_item(CMD_ALLOC, '0);
      queue_item(CMD_FREE, 40'h00_8000_0000);
      queue_item(CMD_FREE, 40'h00_8000_0001);
      queue_item(CMD_FREE, 40'h00_7FFF_F000);
      queue_item(CMD_FREE, 40'h00_8800_0000);
      queue_item(CMD_FREE, 40'hFF_FFFF_F000);
      queue_item(CMD_UNUSED, ADDR_TOP);
      queue_item(CMD_FREE, 40'h00_87FF_F000);
      queue_item(CMD_ALLOC, ADDR_TOP);
      queue_item(CMD_ALLOC, '0);
      queue_item(CMD_INIT, ADDR_TOP);
      queue_item(CMD_FREE, 40'h00_8400_0000);
      queue_item(CMD_ALLOC, '0);

      // Unaligned start rounds up to the next page.
      set_region(64'h1001, 64'h5000);
      queue_item(CMD_INIT, '0);
      for (k = 0; k < 4; k++) queue_item(CMD_ALLOC, '0);

      // Region too small for one page.
      set_region(64'h5001, 64'h6000);
      queue_item(CMD_INIT, '0);
      queue_item(CMD_ALLOC, '0);

      // Stop below start, with start at the top of the address space.
      set_region({24'd0, ADDR_TOP}, 64'h8000);
      queue_item(CMD_INIT, '0);
      queue_item(CMD_FREE, 40'h00_0000_8000);

      // Whole address space: more pages than the stack holds.
      set_region(64'h0, {24'd0, ADDR_TOP});
      queue_item(CMD_INIT, '0);
      queue_item(CMD_FREE, '0);
      queue_item(CMD_ALLOC, '0);
      queue_item(CMD_FREE, 40'hFF_FFFF_F000);

      for (ph = 0; ph < 4; ph++) begin
         r64 = {$urandom, $urandom};
         case (ph)
            0: begin
               base = r64 & 64'h7F_FFFF_F000;
               set_region(base, base + $urandom_range(8, 48) * PAGE_SZ);
            end
            1: begin
               base = r64 & 64'h7F_FFFF_FFFF;
               set_region(base, base + $urandom_range(4, 64) * PAGE_SZ +
                          $urandom_range(0, DEF_PAGE_BYTES - 1));
            end
            2: begin
               base = {24'd0, ADDR_TOP} + 1 - 40 * PAGE_SZ - $urandom_range(0, 4095);
               set_region(base, {24'd0, ADDR_TOP});
            end
            default: begin
               set_region(64'h0, $urandom_range(2, 40) * PAGE_SZ +
                          $urandom_range(0, DEF_PAGE_BYTES - 1));
            end
         endcase
         case (ph)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 54; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 54; end
            default: begin send_idle_pct = 34; stall_pct = 34; end
         endcase
         queue_item(CMD_INIT, '0);
         for (k = 0; k < RANDOM_PER_PHASE; k++) begin
            it = pick_item();
            queue_item(it.cmd, it.addr, it.drain);
         end
      end

      settle();
      repeat (20) @(negedge clock);
      $display("Run covered %0d request beats and %0d response beats over %0d register writes.",
               beats_in, beats_out, cfg_writes);
      $display("Responses by status: ok %0d, empty %0d, bad address %0d, full %0d.",
               sts_seen[0], sts_seen[1], sts_seen[2], sts_seen[3]);
      if (mismatches == 0 && awaited_rsps.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/fpsa_pkg.sv
rtl/core/fpsa_ram.sv
rtl/core/fpsa_ctrl.sv
rtl/core/fpsa_dp.sv
rtl/core/free_page_stack_allocator_core.sv
tb/tb_free_page_stack_allocator_core.sv
